// ----- rtl/lpic_pkg.sv -----
// Shared types and constants of the lane point instance clusterer.
// Holds the controller states and the command and status structs.
// Depends on nothing; every other file refers to it by scoped names.
package lpic_pkg;

    localparam int MAX_CLUSTERS = 12;
    localparam int FEATURE_DIM  = 4;
    localparam int CID_W        = 4;
    localparam int FIDX_W       = 2;
    localparam int MADDR_W      = CID_W + FIDX_W;
    localparam int MEM_DEPTH    = MAX_CLUSTERS * FEATURE_DIM;
    localparam int FEAT_W       = 16;
    localparam int COUNT_W      = 12;
    localparam int XSUM_W       = 23;
    localparam int PIX_W        = 12;
    localparam int MEANX_W      = 18;
    localparam int THR_W        = 40;
    localparam int DSUM_W       = 34;
    localparam int NUM_W        = 28;
    localparam int DIV_W        = 29;
    localparam int DIVC_W       = 5;
    localparam int CFG_IDX_W    = 3;

    localparam logic [FIDX_W-1:0] FIDX_LAST = FIDX_W'(FEATURE_DIM - 1);
    localparam logic [CID_W-1:0]  CID_MAX   = CID_W'(MAX_CLUSTERS);

    typedef enum logic [1:0] {
        KIND_POINT   = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_THR  = 3'd0,
        CFG_INST_THR   = 3'd1,
        CFG_SCALE_X    = 3'd2,
        CFG_SCALE_Y    = 3'd3,
        CFG_MAX_X      = 3'd4,
        CFG_MAX_Y      = 3'd5,
        CFG_MIN_POINTS = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CALC,
        S_DECIDE,
        S_DIST,
        S_DWAIT,
        S_MATCH,
        S_JCHK,
        S_URD,
        S_UMUL,
        S_UDIV,
        S_UWAIT,
        S_UCOMMIT,
        S_OPEN,
        S_EMITP,
        S_FRAME,
        S_RLOAD,
        S_RCHK,
        S_RMUL,
        S_RCMP,
        S_RDIV,
        S_RWAIT,
        S_EMITS,
        S_RNEXT,
        S_EMITE
    } state_t;

    typedef struct packed {
        logic              load_in;
        logic              calc;
        logic              dist_clear;
        logic              dist_issue;
        logic [CID_W-1:0]  k;
        logic [FIDX_W-1:0] p;
        logic              rd_slot;
        logic              slot_new;
        logic              slot_best;
        logic              mul_num;
        logic              div_mean;
        logic              div_mx;
        logic              mean_wr;
        logic              open_wr;
        logic              commit_join;
        logic              commit_open;
        logic              idx_is_slot;
        logic [CID_W-1:0]  idx;
        logic              latch_i;
        logic              rank_mul;
        logic              rank_cmp;
        logic              emit_point;
        logic              emit_sum;
        logic              emit_end;
        logic              used_clear;
    } cmd_t;

    typedef struct packed {
        logic             pt_ok;
        logic             last_c;
        logic             dist_busy;
        logic             match;
        logic [CID_W-1:0] used;
        logic             count_full;
        logic             div_busy;
        logic             i_ok;
        logic             out_free;
    } sts_t;

endpackage

// ----- rtl/lane_point_instance_clusterer_core.sv -----
// Top level of the lane point instance clusterer.
// Instantiates lpic_ctrl (state machine) and lpic_dp (datapath); uses lpic_pkg.
//
//   Channel  | Handshake              | Beat contents
//   ---------+------------------------+---------------------------------------------
//   in       | in_valid / in_ready    | confidence, offsets, features, cell, last_cell
//   out      | out_valid / out_ready  | kind, cluster, pixel, opened, rank, count, mean
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready is always high)
//
// One item at a time. A dropped cell is only checked; a point that opens a
// cluster writes its features as the new means; a point that joins runs the
// serial divider once per feature mean, which sets the join cost.
// On the last cell, each ranked cluster is compared with all used clusters.
// The result register lets the next beat be prepared while out is stalled.
// Reset clears the control state and the cluster count; no clearing pass.
module lane_point_instance_clusterer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [15:0]             confidence,
    input  logic signed [15:0]             offset_x,
    input  logic signed [15:0]             offset_y,
    input  logic signed [15:0]             feature_a,
    input  logic signed [15:0]             feature_b,
    input  logic signed [15:0]             feature_c,
    input  logic signed [15:0]             feature_d,
    input  logic [4:0]                     grid_row,
    input  logic [5:0]                     grid_col,
    input  logic                           last_cell,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     result_kind,
    output logic [3:0]                     cluster_id,
    output logic [11:0]                    pixel_x,
    output logic [11:0]                    pixel_y,
    output logic                           opened_new,
    output logic [3:0]                     lane_rank,
    output logic [11:0]                    point_count,
    output logic [17:0]                    mean_x,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lpic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpic_pkg::THR_W-1:0]     cfg_data
);

    lpic_pkg::cmd_t cmd;
    lpic_pkg::sts_t sts;

    lpic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpic_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .confidence  (confidence),
        .offset_x    (offset_x),
        .offset_y    (offset_y),
        .feature_a   (feature_a),
        .feature_b   (feature_b),
        .feature_c   (feature_c),
        .feature_d   (feature_d),
        .grid_row    (grid_row),
        .grid_col    (grid_col),
        .last_cell   (last_cell),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .cluster_id  (cluster_id),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .opened_new  (opened_new),
        .lane_rank   (lane_rank),
        .point_count (point_count),
        .mean_x      (mean_x),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

endmodule

// ----- rtl/lpic_ctrl.sv -----
// Controller of the clusterer: sequences distance search, mean update,
// cluster opening, frame-end ranking and result beats.
// Depends on lpic_pkg for the state type and the command and status structs.
module lpic_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lpic_pkg::sts_t sts,
    output lpic_pkg::cmd_t cmd
);

    lpic_pkg::state_t state_reg, state_next;
    logic [lpic_pkg::CID_W-1:0]  k_reg, k_next;
    logic [lpic_pkg::CID_W-1:0]  i_reg, i_next;
    logic [lpic_pkg::CID_W-1:0]  j_reg, j_next;
    logic [lpic_pkg::FIDX_W-1:0] p_reg, p_next;
    logic [lpic_pkg::CID_W-1:0]  used_m1;

    assign used_m1 = sts.used - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpic_pkg::S_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        case (state_reg)
            lpic_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = lpic_pkg::S_CALC;
            end
            lpic_pkg::S_CALC:
                state_next = lpic_pkg::S_DECIDE;
            lpic_pkg::S_DECIDE:
            begin
                p_next = '0;
                k_next = '0;
                if (!sts.pt_ok)
                    state_next = lpic_pkg::S_FRAME;
                else if (sts.used == '0)
                    state_next = lpic_pkg::S_OPEN;
                else
                    state_next = lpic_pkg::S_DIST;
            end
            lpic_pkg::S_DIST:
            begin
                p_next = p_reg + 1'b1;
                if (p_reg == lpic_pkg::FIDX_LAST)
                begin
                    k_next = k_reg + 1'b1;
                    if (k_reg == used_m1)
                        state_next = lpic_pkg::S_DWAIT;
                end
            end
            lpic_pkg::S_DWAIT:
            begin
                if (!sts.dist_busy)
                    state_next = lpic_pkg::S_MATCH;
            end
            lpic_pkg::S_MATCH:
            begin
                p_next = '0;
                if (sts.match)
                    state_next = lpic_pkg::S_JCHK;
                else if (sts.used < lpic_pkg::CID_MAX)
                    state_next = lpic_pkg::S_OPEN;
                else
                    state_next = lpic_pkg::S_FRAME;
            end
            lpic_pkg::S_JCHK:
            begin
                p_next = '0;
                if (sts.count_full)
                    state_next = lpic_pkg::S_EMITP;
                else
                    state_next = lpic_pkg::S_URD;
            end
            lpic_pkg::S_URD:
                state_next = lpic_pkg::S_UMUL;
            lpic_pkg::S_UMUL:
                state_next = lpic_pkg::S_UDIV;
            lpic_pkg::S_UDIV:
                state_next = lpic_pkg::S_UWAIT;
            lpic_pkg::S_UWAIT:
            begin
                if (!sts.div_busy)
                begin
                    if (p_reg == lpic_pkg::FIDX_LAST)
                        state_next = lpic_pkg::S_UCOMMIT;
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = lpic_pkg::S_URD;
                    end
                end
            end
            lpic_pkg::S_UCOMMIT:
                state_next = lpic_pkg::S_EMITP;
            lpic_pkg::S_OPEN:
            begin
                p_next = p_reg + 1'b1;
                if (p_reg == lpic_pkg::FIDX_LAST)
                    state_next = lpic_pkg::S_EMITP;
            end
            lpic_pkg::S_EMITP:
            begin
                if (sts.out_free)
                    state_next = lpic_pkg::S_FRAME;
            end
            lpic_pkg::S_FRAME:
            begin
                i_next = '0;
                if (!sts.last_c)
                    state_next = lpic_pkg::S_IDLE;
                else if (sts.used == '0)
                    state_next = lpic_pkg::S_EMITE;
                else
                    state_next = lpic_pkg::S_RLOAD;
            end
            lpic_pkg::S_RLOAD:
                state_next = lpic_pkg::S_RCHK;
            lpic_pkg::S_RCHK:
            begin
                j_next = '0;
                if (sts.i_ok)
                    state_next = lpic_pkg::S_RMUL;
                else
                    state_next = lpic_pkg::S_RNEXT;
            end
            lpic_pkg::S_RMUL:
                state_next = lpic_pkg::S_RCMP;
            lpic_pkg::S_RCMP:
            begin
                if (j_reg == used_m1)
                    state_next = lpic_pkg::S_RDIV;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = lpic_pkg::S_RMUL;
                end
            end
            lpic_pkg::S_RDIV:
                state_next = lpic_pkg::S_RWAIT;
            lpic_pkg::S_RWAIT:
            begin
                if (!sts.div_busy)
                    state_next = lpic_pkg::S_EMITS;
            end
            lpic_pkg::S_EMITS:
            begin
                if (sts.out_free)
                    state_next = lpic_pkg::S_RNEXT;
            end
            lpic_pkg::S_RNEXT:
            begin
                if (i_reg == used_m1)
                    state_next = lpic_pkg::S_EMITE;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = lpic_pkg::S_RLOAD;
                end
            end
            lpic_pkg::S_EMITE:
            begin
                if (sts.out_free)
                    state_next = lpic_pkg::S_IDLE;
            end
            default:
                state_next = lpic_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cmd.k    = k_reg;
        cmd.p    = p_reg;
        cmd.idx  = i_reg;
        case (state_reg)
            lpic_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            lpic_pkg::S_CALC:
                cmd.calc = 1'b1;
            lpic_pkg::S_DECIDE:
            begin
                if (sts.pt_ok)
                begin
                    if (sts.used == '0)
                        cmd.slot_new = 1'b1;
                    else
                        cmd.dist_clear = 1'b1;
                end
            end
            lpic_pkg::S_DIST:
                cmd.dist_issue = 1'b1;
            lpic_pkg::S_MATCH:
            begin
                if (sts.match)
                    cmd.slot_best = 1'b1;
                else if (sts.used < lpic_pkg::CID_MAX)
                    cmd.slot_new = 1'b1;
            end
            lpic_pkg::S_JCHK:
                cmd.idx_is_slot = 1'b1;
            lpic_pkg::S_URD:
            begin
                cmd.idx_is_slot = 1'b1;
                cmd.rd_slot     = 1'b1;
            end
            lpic_pkg::S_UMUL:
            begin
                cmd.idx_is_slot = 1'b1;
                cmd.mul_num     = 1'b1;
            end
            lpic_pkg::S_UDIV:
            begin
                cmd.idx_is_slot = 1'b1;
                cmd.div_mean    = 1'b1;
            end
            lpic_pkg::S_UWAIT:
            begin
                cmd.idx_is_slot = 1'b1;
                cmd.mean_wr     = !sts.div_busy;
            end
            lpic_pkg::S_UCOMMIT:
            begin
                cmd.idx_is_slot = 1'b1;
                cmd.commit_join = 1'b1;
            end
            lpic_pkg::S_OPEN:
            begin
                cmd.open_wr     = 1'b1;
                cmd.commit_open = (p_reg == lpic_pkg::FIDX_LAST);
            end
            lpic_pkg::S_EMITP:
            begin
                cmd.idx_is_slot = 1'b1;
                cmd.emit_point  = sts.out_free;
            end
            lpic_pkg::S_RLOAD:
                cmd.latch_i = 1'b1;
            lpic_pkg::S_RMUL:
            begin
                cmd.idx      = j_reg;
                cmd.rank_mul = 1'b1;
            end
            lpic_pkg::S_RCMP:
                cmd.rank_cmp = 1'b1;
            lpic_pkg::S_RDIV:
                cmd.div_mx = 1'b1;
            lpic_pkg::S_EMITS:
                cmd.emit_sum = sts.out_free;
            lpic_pkg::S_EMITE:
            begin
                cmd.emit_end   = sts.out_free;
                cmd.used_clear = sts.out_free;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

// ----- rtl/lpic_dp.sv -----
// Datapath of the clusterer: input and config registers, feature-mean memory,
// distance pipeline, shared serial divider, rank compare and the result register.
// Depends on lpic_pkg; driven by lpic_ctrl through cmd_t and reports in sts_t.
module lpic_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpic_pkg::cmd_t                cmd,
    output lpic_pkg::sts_t                sts,
    input  logic signed [15:0]            confidence,
    input  logic signed [15:0]            offset_x,
    input  logic signed [15:0]            offset_y,
    input  logic signed [15:0]            feature_a,
    input  logic signed [15:0]            feature_b,
    input  logic signed [15:0]            feature_c,
    input  logic signed [15:0]            feature_d,
    input  logic [4:0]                    grid_row,
    input  logic [5:0]                    grid_col,
    input  logic                          last_cell,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    result_kind,
    output logic [3:0]                    cluster_id,
    output logic [11:0]                   pixel_x,
    output logic [11:0]                   pixel_y,
    output logic                          opened_new,
    output logic [3:0]                    lane_rank,
    output logic [11:0]                   point_count,
    output logic [17:0]                   mean_x,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpic_pkg::THR_W-1:0]    cfg_data
);

    localparam int FW = lpic_pkg::FEAT_W;
    localparam int CW = lpic_pkg::CID_W;
    localparam int PW = lpic_pkg::FIDX_W;
    localparam int NW = lpic_pkg::COUNT_W;

    // Configuration registers.
    logic signed [15:0]           pthr_reg;
    logic [lpic_pkg::THR_W-1:0]   ithr_reg;
    logic [6:0]                   sclx_reg, scly_reg;
    logic [11:0]                  maxx_reg, maxy_reg;
    logic [NW-1:0]                minp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pthr_reg <= 16'sd2867;
            ithr_reg <= 40'd65536;
            sclx_reg <= 7'd10;
            scly_reg <= 7'd15;
            maxx_reg <= 12'd640;
            maxy_reg <= 12'd480;
            minp_reg <= 12'd3;
        end
        else if (cfg_valid)
        begin
            case (lpic_pkg::cfg_idx_t'(cfg_index))
                lpic_pkg::CFG_POINT_THR:  pthr_reg <= cfg_data[15:0];
                lpic_pkg::CFG_INST_THR:   ithr_reg <= cfg_data;
                lpic_pkg::CFG_SCALE_X:    sclx_reg <= cfg_data[6:0];
                lpic_pkg::CFG_SCALE_Y:    scly_reg <= cfg_data[6:0];
                lpic_pkg::CFG_MAX_X:      maxx_reg <= cfg_data[11:0];
                lpic_pkg::CFG_MAX_Y:      maxy_reg <= cfg_data[11:0];
                lpic_pkg::CFG_MIN_POINTS: minp_reg <= cfg_data[11:0];
                default:                  ;
            endcase
        end
    end

    // Input item registers.
    logic signed [15:0] conf_reg, ox_reg, oy_reg;
    logic signed [FW-1:0] f_reg [lpic_pkg::FEATURE_DIM];
    logic [4:0] row_reg;
    logic [5:0] col_reg;
    logic       lastc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            conf_reg  <= confidence;
            ox_reg    <= offset_x;
            oy_reg    <= offset_y;
            f_reg[0]  <= feature_a;
            f_reg[1]  <= feature_b;
            f_reg[2]  <= feature_c;
            f_reg[3]  <= feature_d;
            row_reg   <= grid_row;
            col_reg   <= grid_col;
            lastc_reg <= last_cell;
        end
    end

    // Pixel point: ((offset + cell << 12) * scale) >> 12, truncated toward zero.
    logic signed [19:0] sx, sy;
    logic signed [27:0] prx, pry;
    logic               x_ok, y_ok;
    logic [11:0]        x_reg, y_reg;
    logic               pt_ok_reg;

    assign sx  = 20'(ox_reg) + $signed({2'b00, col_reg, 12'b0});
    assign sy  = 20'(oy_reg) + $signed({3'b000, row_reg, 12'b0});
    assign prx = sx * $signed({1'b0, sclx_reg});
    assign pry = sy * $signed({1'b0, scly_reg});
    // A small negative product truncates to zero and still counts as inside.
    assign x_ok = prx[27] ? (prx > -28'sd4096) : (prx[27:12] <= {4'b0, maxx_reg});
    assign y_ok = pry[27] ? (pry > -28'sd4096) : (pry[27:12] <= {4'b0, maxy_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            x_reg     <= prx[27] ? 12'd0 : prx[23:12];
            y_reg     <= pry[27] ? 12'd0 : pry[23:12];
            pt_ok_reg <= (conf_reg >= pthr_reg) && x_ok && y_ok;
        end
    end

    // Cluster store.
    logic [FW-1:0]                 mem [lpic_pkg::MEM_DEPTH];
    logic [FW-1:0]                 mq_reg;
    logic [NW-1:0]                 cnt_arr [lpic_pkg::MAX_CLUSTERS];
    logic [lpic_pkg::XSUM_W-1:0]   xs_arr  [lpic_pkg::MAX_CLUSTERS];
    logic [CW-1:0]                 used_reg;
    logic [CW-1:0]                 slot_reg;
    logic                          opened_reg;
    logic [CW-1:0]                 sel;
    logic [NW-1:0]                 cnt_sel;
    logic [lpic_pkg::XSUM_W-1:0]   xs_sel;
    logic [lpic_pkg::MADDR_W-1:0]  raddr, waddr;
    logic [FW-1:0]                 wdata;
    logic                          mem_we;

    assign sel     = cmd.idx_is_slot ? slot_reg : cmd.idx;
    assign cnt_sel = cnt_arr[sel];
    assign xs_sel  = xs_arr[sel];
    assign raddr   = cmd.rd_slot ? {slot_reg, cmd.p} : {cmd.k, cmd.p};
    assign waddr   = {slot_reg, cmd.p};
    assign mem_we  = cmd.mean_wr || cmd.open_wr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        mq_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_open)
        begin
            cnt_arr[slot_reg] <= NW'(1);
            xs_arr[slot_reg]  <= lpic_pkg::XSUM_W'(x_reg);
        end
        else if (cmd.commit_join)
        begin
            cnt_arr[slot_reg] <= cnt_sel + 1'b1;
            xs_arr[slot_reg]  <= xs_sel + lpic_pkg::XSUM_W'(x_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else if (cmd.used_clear)
            used_reg <= '0;
        else if (cmd.commit_open)
            used_reg <= used_reg + 1'b1;
    end

    // Distance pipeline: read, square, square again, accumulate.
    logic                         v1_reg, v2_reg, v3_reg;
    logic                         e1_reg, e2_reg, e3_reg;
    logic [CW-1:0]                k1_reg, k2_reg, k3_reg;
    logic [PW-1:0]                p1_reg;
    logic [PW-1:0]                fidx;
    logic signed [FW-1:0]         fsel;
    logic signed [FW:0]           dif;
    logic [FW-1:0]                adif;
    logic [31:0]                  a2_reg;
    logic [63:0]                  a4;
    logic [31:0]                  t_reg;
    logic [lpic_pkg::DSUM_W-1:0]  acc_reg, acc_sum, best_reg;
    logic [CW-1:0]                bestk_reg;
    logic                         bestv_reg;

    assign fidx = v1_reg ? p1_reg : cmd.p;
    assign fsel = f_reg[fidx];
    assign dif  = (FW+1)'(fsel) - (FW+1)'($signed(mq_reg));
    assign adif = dif[FW] ? FW'(-dif) : dif[FW-1:0];
    assign a4   = a2_reg * a2_reg;
    assign acc_sum = acc_reg + lpic_pkg::DSUM_W'(t_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.dist_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= cmd.p;
        k1_reg <= cmd.k;
        e1_reg <= (cmd.p == lpic_pkg::FIDX_LAST);
        k2_reg <= k1_reg;
        e2_reg <= e1_reg;
        a2_reg <= adif * adif;
        k3_reg <= k2_reg;
        e3_reg <= e2_reg;
        t_reg  <= a4[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            bestv_reg <= 1'b0;
        end
        else if (cmd.dist_clear)
        begin
            acc_reg   <= '0;
            bestv_reg <= 1'b0;
        end
        else if (v3_reg)
        begin
            if (e3_reg)
            begin
                acc_reg <= '0;
                // Strict compare keeps the lowest slot on a tie.
                if (!bestv_reg || acc_sum < best_reg)
                begin
                    bestv_reg <= 1'b1;
                    best_reg  <= acc_sum;
                    bestk_reg <= k3_reg;
                end
            end
            else
                acc_reg <= acc_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.slot_new)
        begin
            slot_reg   <= used_reg;
            opened_reg <= 1'b1;
        end
        else if (cmd.slot_best)
        begin
            slot_reg   <= bestk_reg;
            opened_reg <= 1'b0;
        end
    end

    // Running mean numerator: mean * n + f.
    logic signed [lpic_pkg::NUM_W-1:0] prod_m, num_reg;
    logic [lpic_pkg::NUM_W-1:0]        num_mag;
    logic [NW-1:0]                     den;

    assign prod_m  = $signed(mq_reg) * $signed({1'b0, cnt_sel});
    assign num_mag = num_reg[lpic_pkg::NUM_W-1] ? lpic_pkg::NUM_W'(-num_reg) : num_reg;
    assign den     = cnt_sel + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_num)
            num_reg <= prod_m + lpic_pkg::NUM_W'(fsel);
    end

    // Shared restoring divider, one quotient bit per cycle.
    logic [lpic_pkg::DIV_W-1:0]  quo_reg;
    logic [NW-1:0]               rem_reg, dvs_reg;
    logic [DIVC_W_L-1:0]         dcnt_reg;
    logic                        dbusy_reg;
    logic                        neg_reg;
    logic [NW:0]                 rem_sh, rem_sub;

    localparam int DIVC_W_L = lpic_pkg::DIVC_W;

    assign rem_sh  = {rem_reg, quo_reg[lpic_pkg::DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_mean || cmd.div_mx)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= DIVC_W_L'(lpic_pkg::DIV_W);
        end
        else if (dbusy_reg)
        begin
            dcnt_reg  <= dcnt_reg - 1'b1;
            dbusy_reg <= (dcnt_reg != DIVC_W_L'(1));
        end
    end

    logic [NW-1:0]               ci_reg;
    logic [lpic_pkg::XSUM_W-1:0] xi_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_mean)
        begin
            quo_reg <= lpic_pkg::DIV_W'(num_mag) + lpic_pkg::DIV_W'(den >> 1);
            dvs_reg <= den;
            rem_reg <= '0;
            neg_reg <= num_reg[lpic_pkg::NUM_W-1];
        end
        else if (cmd.div_mx)
        begin
            quo_reg <= {xi_reg, 6'b0};
            dvs_reg <= ci_reg;
            rem_reg <= '0;
            neg_reg <= 1'b0;
        end
        else if (dbusy_reg)
        begin
            if (!rem_sub[NW])
            begin
                rem_reg <= rem_sub[NW-1:0];
                quo_reg <= {quo_reg[lpic_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[NW-1:0];
                quo_reg <= {quo_reg[lpic_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign wdata = cmd.open_wr ? fsel :
                   (neg_reg ? FW'(-quo_reg[FW-1:0]) : quo_reg[FW-1:0]);

    // Frame-end ranking: cross-multiplied mean compare against each cluster.
    logic [CW-1:0]  id_reg;
    logic           iok_reg, jok_reg;
    logic [CW-1:0]  rank_reg;
    logic [lpic_pkg::XSUM_W+NW-1:0] pj_reg, pi_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_i)
        begin
            ci_reg   <= cnt_sel;
            xi_reg   <= xs_sel;
            id_reg   <= sel;
            iok_reg  <= (cnt_sel != '0) && (cnt_sel >= minp_reg);
            rank_reg <= CW'(1);
        end
        else if (cmd.rank_cmp)
        begin
            if (jok_reg && (pj_reg < pi_reg))
                rank_reg <= rank_reg + 1'b1;
        end
        if (cmd.rank_mul)
        begin
            pj_reg  <= xs_sel * ci_reg;
            pi_reg  <= xi_reg * cnt_sel;
            jok_reg <= (cnt_sel != '0) && (cnt_sel >= minp_reg);
        end
    end

    // Result register.
    logic             ov_reg;
    logic [1:0]       kind_reg;
    logic [CW-1:0]    oid_reg, orank_reg;
    logic [11:0]      ox_out_reg, oy_out_reg, ocnt_reg;
    logic             oopen_reg, olast_reg;
    logic [17:0]      omx_reg;
    logic             emit;

    assign emit = cmd.emit_point || cmd.emit_sum || cmd.emit_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (emit)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_point)
        begin
            kind_reg   <= lpic_pkg::KIND_POINT;
            oid_reg    <= slot_reg;
            ox_out_reg <= x_reg;
            oy_out_reg <= y_reg;
            oopen_reg  <= opened_reg;
            orank_reg  <= '0;
            ocnt_reg   <= cnt_sel;
            omx_reg    <= '0;
            olast_reg  <= !lastc_reg;
        end
        else if (cmd.emit_sum)
        begin
            kind_reg   <= lpic_pkg::KIND_SUMMARY;
            oid_reg    <= id_reg;
            ox_out_reg <= '0;
            oy_out_reg <= '0;
            oopen_reg  <= 1'b0;
            orank_reg  <= rank_reg;
            ocnt_reg   <= ci_reg;
            omx_reg    <= quo_reg[17:0];
            olast_reg  <= 1'b0;
        end
        else if (cmd.emit_end)
        begin
            kind_reg   <= lpic_pkg::KIND_END;
            oid_reg    <= '0;
            ox_out_reg <= '0;
            oy_out_reg <= '0;
            oopen_reg  <= 1'b0;
            orank_reg  <= '0;
            ocnt_reg   <= '0;
            omx_reg    <= '0;
            olast_reg  <= 1'b1;
        end
    end

    assign out_valid   = ov_reg;
    assign result_kind = kind_reg;
    assign cluster_id  = oid_reg;
    assign pixel_x     = ox_out_reg;
    assign pixel_y     = oy_out_reg;
    assign opened_new  = oopen_reg;
    assign lane_rank   = orank_reg;
    assign point_count = ocnt_reg;
    assign mean_x      = omx_reg;
    assign last        = olast_reg;

    always_comb
    begin
        sts            = '0;
        sts.pt_ok      = pt_ok_reg;
        sts.last_c     = lastc_reg;
        sts.dist_busy  = v1_reg || v2_reg || v3_reg;
        sts.match      = bestv_reg && (lpic_pkg::THR_W'(best_reg) <= ithr_reg);
        sts.used       = used_reg;
        sts.count_full = cnt_sel[NW-1];
        sts.div_busy   = dbusy_reg;
        sts.i_ok       = iok_reg;
        sts.out_free   = !ov_reg || out_ready;
    end

endmodule
